// ===== rtl/prefix_trie_superset_match_assert.svh =====
// ----------------------------------------------------------------------------
// prefix trie superset match assertion macros
// shared property wrappers, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PREFIX_TRIE_SUPERSET_MATCH_ASSERT_SVH
`define PREFIX_TRIE_SUPERSET_MATCH_ASSERT_SVH

// same-cycle implication
`define PTSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsm_pkg
// shared constants and types of the prefix trie superset match block
// ----------------------------------------------------------------------------
package ptsm_pkg;

  localparam int NODE_COUNT   = 1024;
  localparam int ADDRESS_BITS = 32;

  localparam int NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int FREE_W     = NODE_IDX_W + 1;
  localparam int LEN_W      = 6;
  localparam int STATUS_W   = 3;
  localparam int ENTRY_W    = 2 * NODE_IDX_W + 1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] left;
    logic [NODE_IDX_W-1:0] right;
    logic                  mark;
  } node_t;

endpackage

// ===== rtl/prefix_trie_superset_match.sv =====
// ----------------------------------------------------------------------------
// prefix_trie_superset_match
// binary trie of address prefixes with insert and covering-prefix search
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// command   in         start / busy               op_i, address_i, prefix_length_i
// result    out        result_strobe_o (1 cycle)  status_o, match_address_o,
//                                                 match_length_o, last_o
//
// one trie level is visited per cycle through the single read port of the
// node ram; an insert passes through an allocate state on each level it
// allocates, since the parent update and the new node clear share the one
// write port. results appear in the cycle after they are formed, one per
// cycle at most.
// reset clears control state and the root; other nodes are cleared on allocation.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "prefix_trie_superset_match_assert.svh"

module prefix_trie_superset_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [ptsm_pkg::ADDRESS_BITS-1:0]   address_i,
  input  logic [ptsm_pkg::LEN_W-1:0]          prefix_length_i,
  output logic                                result_strobe_o,
  output logic [ptsm_pkg::STATUS_W-1:0]       status_o,
  output logic [ptsm_pkg::ADDRESS_BITS-1:0]   match_address_o,
  output logic [ptsm_pkg::LEN_W-1:0]          match_length_o,
  output logic                                last_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  localparam int AW = ptsm_pkg::ADDRESS_BITS;
  localparam int IW = ptsm_pkg::NODE_IDX_W;
  localparam int FW = ptsm_pkg::FREE_W;
  localparam int LW = ptsm_pkg::LEN_W;
  localparam int SW = ptsm_pkg::STATUS_W;

  logic [1:0]    state_q, state_d;
  logic          op_q, op_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] addr_sh_q, addr_sh_d;
  logic [AW-1:0] mask_q, mask_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] depth_q, depth_d;
  logic [IW-1:0] node_q, node_d;
  logic          fresh_q, fresh_d;
  logic [FW-1:0] free_q, free_d;
  logic          root_valid_q, root_valid_d;
  logic          pend_valid_q, pend_valid_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [LW-1:0] pend_len_q, pend_len_d;

  logic          strobe_q, strobe_d;
  logic [SW-1:0] status_q, status_d;
  logic [AW-1:0] maddr_q, maddr_d;
  logic [LW-1:0] mlen_q, mlen_d;
  logic          last_q, last_d;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  ptsm_pkg::node_t              ram_wdata;
  logic [ptsm_pkg::ENTRY_W-1:0] ram_rdata;
  ptsm_pkg::node_t              cur;
  logic [IW-1:0]                child;
  logic                         accept;
  logic                         at_len;
  logic                         pool_full;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  ptsm_ram #(
    .WIDTH(ptsm_pkg::ENTRY_W),
    .DEPTH(ptsm_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(node_d),
    .rdata_o(ram_rdata)
  );

  // a freshly allocated node is known empty; the root reads empty until written
  always_comb begin
    if (fresh_q || (node_q == '0 && !root_valid_q)) begin
      cur = '0;
    end else begin
      cur = ptsm_pkg::node_t'(ram_rdata);
    end
  end

  assign child     = addr_sh_q[AW-1] ? cur.right : cur.left;
  assign at_len    = (depth_q == len_q);
  assign pool_full = (free_q == FW'(ptsm_pkg::NODE_COUNT));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    addr_d       = addr_q;
    addr_sh_d    = addr_sh_q;
    mask_d       = mask_q;
    len_d        = len_q;
    depth_d      = depth_q;
    node_d       = node_q;
    fresh_d      = fresh_q;
    free_d       = free_q;
    pend_valid_d = pend_valid_q;
    pend_addr_d  = pend_addr_q;
    pend_len_d   = pend_len_q;
    strobe_d     = 1'b0;
    status_d     = status_q;
    maddr_d      = maddr_q;
    mlen_d       = mlen_q;
    last_d       = last_q;
    ram_we       = 1'b0;
    ram_waddr    = node_q;
    ram_wdata    = cur;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d      = S_EVAL;
          op_d         = op_i;
          addr_d       = address_i;
          addr_sh_d    = address_i;
          mask_d       = '0;
          len_d        = (prefix_length_i > LW'(AW)) ? LW'(AW) : prefix_length_i;
          depth_d      = '0;
          node_d       = '0;
          fresh_d      = 1'b0;
          pend_valid_d = 1'b0;
        end
      end

      S_EVAL: begin
        if (op_q == ptsm_pkg::OP_INSERT) begin
          if (at_len) begin
            strobe_d = 1'b1;
            maddr_d  = '0;
            mlen_d   = '0;
            last_d   = 1'b1;
            state_d  = S_IDLE;
            if (cur.mark) begin
              status_d = ptsm_pkg::ST_PRESENT;
            end else begin
              status_d       = ptsm_pkg::ST_INSERTED;
              ram_we         = 1'b1;
              ram_wdata.mark = 1'b1;
            end
          end else if (child != '0) begin
            node_d    = child;
            depth_d   = depth_q + 1'b1;
            addr_sh_d = addr_sh_q << 1;
            fresh_d   = 1'b0;
          end else if (pool_full) begin
            strobe_d = 1'b1;
            status_d = ptsm_pkg::ST_FULL;
            maddr_d  = '0;
            mlen_d   = '0;
            last_d   = 1'b1;
            state_d  = S_IDLE;
          end else begin
            // link the parent to the next free node, clear that node next cycle
            ram_we = 1'b1;
            if (addr_sh_q[AW-1]) begin
              ram_wdata.right = free_q[IW-1:0];
            end else begin
              ram_wdata.left = free_q[IW-1:0];
            end
            state_d = S_ALLOC;
          end
        end else begin
          if (cur.mark) begin
            if (pend_valid_q) begin
              strobe_d = 1'b1;
              status_d = ptsm_pkg::ST_MATCH;
              maddr_d  = pend_addr_q;
              mlen_d   = pend_len_q;
              last_d   = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_addr_d  = addr_q & mask_q;
            pend_len_d   = depth_q;
          end
          if (at_len || child == '0) begin
            state_d = S_FLUSH;
          end else begin
            node_d    = child;
            depth_d   = depth_q + 1'b1;
            addr_sh_d = addr_sh_q << 1;
            mask_d    = {1'b1, mask_q[AW-1:1]};
          end
        end
      end

      S_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = free_q[IW-1:0];
        ram_wdata = '0;
        node_d    = free_q[IW-1:0];
        free_d    = free_q + 1'b1;
        depth_d   = depth_q + 1'b1;
        addr_sh_d = addr_sh_q << 1;
        fresh_d   = 1'b1;
        state_d   = S_EVAL;
      end

      S_FLUSH: begin
        strobe_d     = 1'b1;
        last_d       = 1'b1;
        pend_valid_d = 1'b0;
        state_d      = S_IDLE;
        if (pend_valid_q) begin
          status_d = ptsm_pkg::ST_MATCH;
          maddr_d  = pend_addr_q;
          mlen_d   = pend_len_q;
        end else begin
          status_d = ptsm_pkg::ST_NOMATCH;
          maddr_d  = '0;
          mlen_d   = '0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign root_valid_d = root_valid_q || (ram_we && ram_waddr == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_q       <= FW'(1);
      root_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
      fresh_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_q       <= free_d;
      root_valid_q <= root_valid_d;
      pend_valid_q <= pend_valid_d;
      strobe_q     <= strobe_d;
      fresh_q      <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    addr_sh_q   <= addr_sh_d;
    mask_q      <= mask_d;
    len_q       <= len_d;
    depth_q     <= depth_d;
    node_q      <= node_d;
    pend_addr_q <= pend_addr_d;
    pend_len_q  <= pend_len_d;
    status_q    <= status_d;
    maddr_q     <= maddr_d;
    mlen_q      <= mlen_d;
    last_q      <= last_d;
  end

  assign result_strobe_o = strobe_q;
  assign status_o        = status_q;
  assign match_address_o = maddr_q;
  assign match_length_o  = mlen_q;
  assign last_o          = last_q;

  `PTSM_ASSERT_NOW(a_free_in_range, 1'b1, free_q <= FW'(ptsm_pkg::NODE_COUNT) && free_q != '0,
    "free node pointer out of range")
  `PTSM_ASSERT_NOW(a_alloc_has_room, state_q == S_ALLOC, !pool_full,
    "allocation with an exhausted pool")
  `PTSM_ASSERT_NOW(a_non_last_is_match, result_strobe_o && !last_o, status_o == ptsm_pkg::ST_MATCH,
    "non-final result that is not a match")
  `PTSM_ASSERT_NEXT(a_gap_after_last, result_strobe_o && last_o, !result_strobe_o,
    "result directly after the final result of an item")

endmodule

// ===== rtl/ptsm_ram.sv =====
// ----------------------------------------------------------------------------
// ptsm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ptsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
